// File: hdl/endp_pkg.sv
// Package for the ellipse nearest direction point block.
// Holds widths, pipeline depth, the Q1.15 trig tables, the candidate type and helpers.
// No dependencies.
package endp_pkg;

  localparam int RING_COUNT  = 5;
  localparam int ANGLE_COUNT = 35;

  // Candidates: the centre plus one per ring and angle.
  localparam int NC      = RING_COUNT * ANGLE_COUNT + 1;
  localparam int LV      = $clog2(NC);
  localparam int NP      = 1 << LV;
  localparam int TREE_ST = (LV + 1) / 2;

  // Pipeline stage numbers.
  localparam int ST_IN  = 1;
  localparam int ST_DQ  = 2;
  localparam int ST_EX  = 5;
  localparam int ST_SQ  = 6;
  localparam int ST_SUM = 7;
  localparam int NS     = ST_SUM + TREE_ST + 1;

  localparam int COORD_W = 24;
  localparam int RAD_W   = 16;
  localparam int RING_W  = $clog2(RING_COUNT + 1);
  localparam int ANG_W   = $clog2(ANGLE_COUNT + 1);
  localparam int DQ_W    = COORD_W + 1;
  localparam int OFF_W   = 19;
  localparam int EX_W    = DQ_W + 1;
  localparam int SQ_W    = 2 * EX_W - 1;
  localparam int DIST_W  = SQ_W + 1;
  localparam int MAG_W   = 32;
  localparam int N_W     = MAG_W + 3;
  localparam int T_W     = 20;
  localparam int TGT_W   = 18;

  // Division by five after the Q15 shift: multiply by the reciprocal.
  localparam int          RDIV_SH  = 22;
  localparam logic [19:0] RDIV_MUL = 20'd838861;
  localparam int          PROD_W   = T_W + 20;

  // Index i holds the angle 1 + 10*i degrees.
  localparam logic signed [16:0] COS_Q15 [0:ANGLE_COUNT] = '{
    17'sd32763, 17'sd32166, 17'sd30592, 17'sd28088, 17'sd24730, 17'sd20622,
    17'sd15886, 17'sd10668, 17'sd5126, -17'sd572, -17'sd6252, -17'sd11743,
    -17'sd16877, -17'sd21498, -17'sd25466, -17'sd28660, -17'sd30983, -17'sd32365,
    -17'sd32763, -17'sd32166, -17'sd30592, -17'sd28088, -17'sd24730, -17'sd20622,
    -17'sd15886, -17'sd10668, -17'sd5126, 17'sd572, 17'sd6252, 17'sd11743,
    17'sd16877, 17'sd21498, 17'sd25466, 17'sd28660, 17'sd30983, 17'sd32365
  };
  localparam logic signed [16:0] SIN_Q15 [0:ANGLE_COUNT] = '{
    17'sd572, 17'sd6252, 17'sd11743, 17'sd16877, 17'sd21498, 17'sd25466,
    17'sd28660, 17'sd30983, 17'sd32365, 17'sd32763, 17'sd32166, 17'sd30592,
    17'sd28088, 17'sd24730, 17'sd20622, 17'sd15886, 17'sd10668, 17'sd5126,
    -17'sd572, -17'sd6252, -17'sd11743, -17'sd16877, -17'sd21498, -17'sd25466,
    -17'sd28660, -17'sd30983, -17'sd32365, -17'sd32763, -17'sd32166, -17'sd30592,
    -17'sd28088, -17'sd24730, -17'sd20622, -17'sd15886, -17'sd10668, -17'sd5126
  };

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_A = 2'd2,
    REG_RADIUS_B = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DIST_W-1:0] sqd;
    logic [RING_W-1:0] ring;
    logic [ANG_W-1:0]  ang;
  } cand_t;

  // Magnitude of a trig constant.
  function automatic logic [15:0] trig_mag(input logic signed [16:0] v);
    logic signed [16:0] a;
    a = (v < 0) ? -v : v;
    return a[15:0];
  endfunction

  // Clamp a sum to the signed 24-bit coordinate range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    logic [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/ellipse_nearest_direction_point.sv
// An input transfer passes the input register, the distance lanes, the minimum tree and the output register.
// Throughput: one query per cycle; the distance lanes and the minimum tree are fully
// pipelined, so only a stalled output holds items back, and bubbles still fill.
// After a register write the derived offsets settle through the registers of endp_offsets.
// Reset (rst_ni low, asynchronous) clears the configuration registers and all stage valid bits.
// Top level; instantiates endp_offsets, endp_dist and endp_min; uses endp_pkg.
module ellipse_nearest_direction_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Query stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // query_x[23:0], query_y[47:24]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // target_x[23:0], target_y[47:24],
                                     // best_angle[56:48], best_ring[59:57], zero[63:60]
);
  import endp_pkg::*;

  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]          ra_q, rb_q;
  reg_idx_e                  widx;
  logic                      wr;

  // Register writes.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      ra_q <= '0;
      rb_q <= '0;
    end else if (wr) begin
      case (widx)
        REG_CENTER_X: cx_q <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: cy_q <= pwdata[COORD_W-1:0];
        REG_RADIUS_A: ra_q <= pwdata[RAD_W-1:0];
        REG_RADIUS_B: rb_q <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (widx)
      REG_CENTER_X: prdata = 32'(unsigned'(cx_q));
      REG_CENTER_Y: prdata = 32'(unsigned'(cy_q));
      REG_RADIUS_A: prdata = 32'(ra_q);
      REG_RADIUS_B: prdata = 32'(rb_q);
      default:      prdata = '0;
    endcase
  end

  // Stage valid bits and enables; a stage loads when empty or when its successor moves.
  logic [NS:1] v_q, en;

  always_comb begin
    en[NS] = !v_q[NS] || m_axis_tready;
    for (int s = NS - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign s_axis_tready = en[ST_IN];
  assign m_axis_tvalid = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid;
      end
      for (int s = 2; s <= NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Input register.
  logic signed [COORD_W-1:0] qx_q, qy_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      qx_q <= s_axis_tdata[COORD_W-1:0];
      qy_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
    end
  end

  // Offsets, distances and the minimum search.
  logic signed [OFF_W-1:0] ring_ox [1:RING_COUNT][1:ANGLE_COUNT];
  logic signed [OFF_W-1:0] ring_oy [1:RING_COUNT][1:ANGLE_COUNT];
  logic signed [TGT_W-1:0] tgt_ox [0:ANGLE_COUNT];
  logic signed [TGT_W-1:0] tgt_oy [0:ANGLE_COUNT];
  cand_t                   cand [0:NC-1];
  cand_t                   best;

  endp_offsets u_offsets (
    .clk_i      (clk_i),
    .radius_a_i (ra_q),
    .radius_b_i (rb_q),
    .ring_ox_o  (ring_ox),
    .ring_oy_o  (ring_oy),
    .tgt_ox_o   (tgt_ox),
    .tgt_oy_o   (tgt_oy)
  );

  endp_dist u_dist (
    .clk_i     (clk_i),
    .en_i      (en),
    .qx_i      (qx_q),
    .qy_i      (qy_q),
    .cx_i      (cx_q),
    .cy_i      (cy_q),
    .ring_ox_i (ring_ox),
    .ring_oy_i (ring_oy),
    .cand_o    (cand)
  );

  endp_min u_min (
    .clk_i  (clk_i),
    .en_i   (en),
    .cand_i (cand),
    .best_o (best)
  );

  // Output register: point on the full ellipse at the winning angle.
  logic [COORD_W-1:0] tx_q, ty_q;
  logic [8:0]         ang_q;
  logic [2:0]         ring_q;
  logic [3:0]         ring_w;

  assign ring_w = 4'(best.ring);

  always_ff @(posedge clk_i) begin
    if (en[NS]) begin
      tx_q   <= sat_coord((COORD_W+1)'(cx_q) + (COORD_W+1)'(tgt_ox[best.ang]));
      ty_q   <= sat_coord((COORD_W+1)'(cy_q) + (COORD_W+1)'(tgt_oy[best.ang]));
      ang_q  <= 9'd1 + 9'(best.ang) * 9'd10;
      ring_q <= ring_w[2:0];
    end
  end

  assign m_axis_tdata = {4'b0, ring_q, ang_q, ty_q, tx_q};

endmodule

// File: hdl/endp_offsets.sv
// Sample and target offsets derived from the half axes, recomputed every cycle.
// Ring offsets: three register stages: product, ring scaling with rounding shift, division
// by five. Target offsets take the product and rounding shift only. Depends on endp_pkg.
module endp_offsets (
  input  logic                                 clk_i,
  input  logic [endp_pkg::RAD_W-1:0]           radius_a_i,
  input  logic [endp_pkg::RAD_W-1:0]           radius_b_i,
  output logic signed [endp_pkg::OFF_W-1:0]
    ring_ox_o [1:endp_pkg::RING_COUNT][1:endp_pkg::ANGLE_COUNT],
  output logic signed [endp_pkg::OFF_W-1:0]
    ring_oy_o [1:endp_pkg::RING_COUNT][1:endp_pkg::ANGLE_COUNT],
  output logic signed [endp_pkg::TGT_W-1:0]    tgt_ox_o [0:endp_pkg::ANGLE_COUNT],
  output logic signed [endp_pkg::TGT_W-1:0]    tgt_oy_o [0:endp_pkg::ANGLE_COUNT]
);
  import endp_pkg::*;

  for (genvar j = 0; j <= ANGLE_COUNT; j++) begin : g_ang
    localparam logic [15:0] CMAG = trig_mag(COS_Q15[j]);
    localparam logic [15:0] SMAG = trig_mag(SIN_Q15[j]);
    localparam logic        CNEG = COS_Q15[j] < 0;
    localparam logic        SNEG = SIN_Q15[j] < 0;

    logic [MAG_W-1:0] ma_q, mb_q;
    logic [TGT_W-2:0] ta, tb;

    // Radius times trig magnitude.
    always_ff @(posedge clk_i) begin
      ma_q <= MAG_W'(radius_a_i) * MAG_W'(CMAG);
      mb_q <= MAG_W'(radius_b_i) * MAG_W'(SMAG);
    end

    // Target offset on the full ellipse, halves away from zero.
    assign ta = (TGT_W-1)'((ma_q + MAG_W'(16384)) >> 15);
    assign tb = (TGT_W-1)'((mb_q + MAG_W'(16384)) >> 15);
    always_ff @(posedge clk_i) begin
      tgt_ox_o[j] <= CNEG ? -$signed({1'b0, ta}) : $signed({1'b0, ta});
      tgt_oy_o[j] <= SNEG ? -$signed({1'b0, tb}) : $signed({1'b0, tb});
    end

    if (j > 0) begin : g_ring_set
      for (genvar k = 1; k <= RING_COUNT; k++) begin : g_ring
        logic [N_W-1:0]    na, nb;
        logic [T_W-1:0]    ta_q, tb_q;
        logic [PROD_W-1:0] pa, pb;
        logic [OFF_W-2:0]  qa, qb;

        // Scale by the ring number and round the Q15 part away.
        assign na = N_W'(k) * N_W'(ma_q) + N_W'(81920);
        assign nb = N_W'(k) * N_W'(mb_q) + N_W'(81920);
        always_ff @(posedge clk_i) begin
          ta_q <= T_W'(na >> 15);
          tb_q <= T_W'(nb >> 15);
        end

        // Divide by five through the reciprocal and restore the sign.
        assign pa = PROD_W'(ta_q) * PROD_W'(RDIV_MUL);
        assign pb = PROD_W'(tb_q) * PROD_W'(RDIV_MUL);
        assign qa = (OFF_W-1)'(pa >> RDIV_SH);
        assign qb = (OFF_W-1)'(pb >> RDIV_SH);
        always_ff @(posedge clk_i) begin
          ring_ox_o[k][j] <= CNEG ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
          ring_oy_o[k][j] <= SNEG ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
        end
      end
    end
  end

endmodule

// File: hdl/endp_dist.sv
// Squared distance lanes: one per candidate, six register stages deep.
// Stages: query minus centre, two delay stages, differences, squares, sums.
// Depends on endp_pkg.
module endp_dist (
  input  logic                                clk_i,
  input  logic [endp_pkg::NS:1]               en_i,
  input  logic signed [endp_pkg::COORD_W-1:0] qx_i,
  input  logic signed [endp_pkg::COORD_W-1:0] qy_i,
  input  logic signed [endp_pkg::COORD_W-1:0] cx_i,
  input  logic signed [endp_pkg::COORD_W-1:0] cy_i,
  input  logic signed [endp_pkg::OFF_W-1:0]
    ring_ox_i [1:endp_pkg::RING_COUNT][1:endp_pkg::ANGLE_COUNT],
  input  logic signed [endp_pkg::OFF_W-1:0]
    ring_oy_i [1:endp_pkg::RING_COUNT][1:endp_pkg::ANGLE_COUNT],
  output endp_pkg::cand_t                     cand_o [0:endp_pkg::NC-1]
);
  import endp_pkg::*;

  logic signed [DQ_W-1:0] dqx_q [ST_DQ:ST_EX-1];
  logic signed [DQ_W-1:0] dqy_q [ST_DQ:ST_EX-1];

  // Query relative to the centre, then delayed until the offsets settle.
  always_ff @(posedge clk_i) begin
    if (en_i[ST_DQ]) begin
      dqx_q[ST_DQ] <= DQ_W'(qx_i) - DQ_W'(cx_i);
      dqy_q[ST_DQ] <= DQ_W'(qy_i) - DQ_W'(cy_i);
    end
    for (int s = ST_DQ + 1; s < ST_EX; s++) begin
      if (en_i[s]) begin
        dqx_q[s] <= dqx_q[s-1];
        dqy_q[s] <= dqy_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < NC; l++) begin : g_lane
    localparam int K = (l == 0) ? 0 : (l - 1) / ANGLE_COUNT + 1;
    localparam int I = (l == 0) ? 0 : (l - 1) % ANGLE_COUNT + 1;

    logic signed [OFF_W-1:0] ox, oy;
    logic signed [EX_W-1:0]  ex_q, ey_q;
    logic signed [2*EX_W-1:0] px, py;
    logic [SQ_W-1:0]         sx_q, sy_q;
    logic [DIST_W-1:0]       d_q;

    if (l == 0) begin : g_ctr
      assign ox = '0;
      assign oy = '0;
    end else begin : g_smp
      assign ox = ring_ox_i[K][I];
      assign oy = ring_oy_i[K][I];
    end

    assign px = ex_q * ex_q;
    assign py = ey_q * ey_q;

    always_ff @(posedge clk_i) begin
      if (en_i[ST_EX]) begin
        ex_q <= EX_W'(ox) - EX_W'(dqx_q[ST_EX-1]);
        ey_q <= EX_W'(oy) - EX_W'(dqy_q[ST_EX-1]);
      end
      if (en_i[ST_SQ]) begin
        sx_q <= px[SQ_W-1:0];
        sy_q <= py[SQ_W-1:0];
      end
      if (en_i[ST_SUM]) begin
        d_q <= DIST_W'(sx_q) + DIST_W'(sy_q);
      end
    end

    assign cand_o[l].sqd  = d_q;
    assign cand_o[l].ring = RING_W'(K);
    assign cand_o[l].ang  = ANG_W'(I);
  end

endmodule

// File: hdl/endp_min.sv
// Minimum search over all candidates as a binary tree, registered every two levels.
// On equal distances the lower candidate index wins.
// Depends on endp_pkg.
module endp_min (
  input  logic                  clk_i,
  input  logic [endp_pkg::NS:1] en_i,
  input  endp_pkg::cand_t       cand_i [0:endp_pkg::NC-1],
  output endp_pkg::cand_t       best_o
);
  import endp_pkg::*;

  cand_t node [0:LV][0:NP-1];

  // Leaves; padding carries the largest distance and never wins.
  for (genvar n = 0; n < NP; n++) begin : g_leaf
    if (n < NC) begin : g_real
      assign node[0][n] = cand_i[n];
    end else begin : g_pad
      assign node[0][n] = '{sqd: '1, ring: '0, ang: '0};
    end
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar n = 0; n < NP; n++) begin : g_node
      if (n < (NP >> l)) begin : g_used
        cand_t pick;
        assign pick = (node[l-1][2*n+1].sqd < node[l-1][2*n].sqd) ?
                      node[l-1][2*n+1] : node[l-1][2*n];
        if ((l % 2 == 0) || (l == LV)) begin : g_reg
          cand_t r_q;
          always_ff @(posedge clk_i) begin
            if (en_i[ST_SUM + (l + 1) / 2]) begin
              r_q <= pick;
            end
          end
          assign node[l][n] = r_q;
        end else begin : g_comb
          assign node[l][n] = pick;
        end
      end else begin : g_unused
        assign node[l][n] = '0;
      end
    end
  end

  assign best_o = node[LV][0];

endmodule

// File: hdl/endp_chk.sv
// Port-level checker for the ellipse nearest direction point block, bound to the top.
// Depends on the top level's port list only.
module endp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The centre always reports the one-degree direction.
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[59:57] == 3'd0) |-> m_axis_tdata[56:48] == 9'd1)
    else $error("centre result with wrong angle");

  // A ring sample never reports the centre's angle.
  a_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[59:57] != 3'd0) |-> m_axis_tdata[56:48] != 9'd1)
    else $error("ring result with centre angle");

  // Ring and angle stay in range, padding stays zero.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[59:57] <= 3'd5) && (m_axis_tdata[56:48] <= 9'd351)
                      && (m_axis_tdata[63:60] == 4'd0))
    else $error("result field out of range");

endmodule

bind ellipse_nearest_direction_point endp_chk u_chk (.*);
